// File: hw/rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the min-tracking stack.
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

  localparam int unsigned DEPTH_DEFAULT = 256;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned CAP_W         = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_FULL      = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/min_tracking_stack_core.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_core
// LIFO stack of signed 32-bit words that also tracks the running minimum.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a command by raising start with func and push_value while busy is
//   low; the word is taken at that clock edge. func = push stores push_value,
//   func = pop removes the top entry.
//   Every command yields one result word, shown for exactly one cycle with
//   done high: popped_value, current_min, is_empty, is_full and status.
//   The receiver cannot stall; it must capture the word while done is high.
// Timing:
//   A push, a refused push, a pop of the last entry and a pop on an empty
//   stack report in the cycle after acceptance and take one command a cycle.
//   A pop that leaves entries behind holds busy high in the ST_READ state
//   while the new top entry (value and minimum) is read back from the stack
//   RAM, whose read data is registered; the result is reported after ST_READ.
//   The top entry itself lives in registers, so pushes never touch the read
//   port.
// Configuration:
//   cfg_wr_en writes capacity_limit; write only while no command is pending.
// Reset:
//   rst empties the stack and sets capacity_limit to 256. The RAM contents
//   are not cleared; entries above the count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module min_tracking_stack_core #(
  parameter int unsigned DEPTH = mts_pkg::DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [mts_pkg::CAP_W-1:0]         cfg_wr_data,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              func,
  input  wire logic signed [mts_pkg::DATA_W-1:0] push_value,
  output logic                                   done,
  output logic signed [mts_pkg::DATA_W-1:0]      popped_value,
  output logic signed [mts_pkg::DATA_W-1:0]      current_min,
  output logic                                   is_empty,
  output logic                                   is_full,
  output logic [1:0]                             status
);

  import mts_pkg::*;

  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int unsigned RAM_W  = 2 * DATA_W;

  // Control and configuration state
  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [CAP_W-1:0]   capacity_limit;

  // Top of stack kept in registers
  logic signed [DATA_W-1:0] top_val, top_val_next;
  logic signed [DATA_W-1:0] top_min, top_min_next;

  // Result word
  logic                     done_next;
  logic signed [DATA_W-1:0] popped_next;
  status_t                  status_next;

  // RAM interface
  logic                     ram_we, ram_re;
  logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
  logic [RAM_W-1:0]         ram_wdata, ram_rdata;

  logic                     accept, is_push;
  logic [CMP_W-1:0]         cap_ext, eff_cap;
  logic                     full_now;
  logic                     push_ok, push_refused, pop_empty, pop_last, pop_deep;
  logic signed [DATA_W-1:0] new_min;

  localparam logic signed [DATA_W-1:0] ALL_ONES = '1;

  // Clamp capacity into one..DEPTH
  always_comb begin
    cap_ext = CMP_W'(capacity_limit);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign accept   = start && !busy;
  assign is_push  = (func == FUNC_PUSH);
  assign full_now = (CMP_W'(count) >= eff_cap);

  assign push_ok      = accept && is_push && !full_now;
  assign push_refused = accept && is_push && full_now;
  assign pop_empty    = accept && !is_push && (count == '0);
  assign pop_last     = accept && !is_push && (count == CNT_W'(1));
  assign pop_deep     = accept && !is_push && (count >= CNT_W'(2));

  // A tie with the running minimum takes the pushed value; same number.
  assign new_min = ((count == '0) || (push_value <= top_min)) ? push_value : top_min;

  // Write the pushed entry at the current count; read the entry below the
  // top when a pop uncovers it.
  assign ram_we    = push_ok;
  assign ram_waddr = count[ADDR_W-1:0];
  assign ram_wdata = {push_value, new_min};
  assign ram_re    = pop_deep;
  assign ram_raddr = ADDR_W'(count - CNT_W'(2));

  mts_ram #(
    .WIDTH (RAM_W),
    .DEPTH (DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop_deep) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    unique case (state)
      ST_IDLE: busy = 1'b0;
      ST_READ: busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  // Datapath next values
  always_comb begin
    count_next   = count;
    top_val_next = top_val;
    top_min_next = top_min;
    popped_next  = '0;
    status_next  = STATUS_OK;
    done_next    = 1'b0;

    if (state == ST_READ) begin
      // Load the uncovered entry as the new top, report the removed one
      top_val_next = ram_rdata[RAM_W-1:DATA_W];
      top_min_next = ram_rdata[DATA_W-1:0];
      popped_next  = top_val;
      done_next    = 1'b1;
    end else if (push_ok) begin
      count_next   = count + CNT_W'(1);
      top_val_next = push_value;
      top_min_next = new_min;
      done_next    = 1'b1;
    end else if (push_refused) begin
      status_next  = STATUS_FULL;
      done_next    = 1'b1;
    end else if (pop_empty) begin
      popped_next  = ALL_ONES;
      status_next  = STATUS_UNDERFLOW;
      done_next    = 1'b1;
    end else if (pop_last) begin
      count_next   = '0;
      popped_next  = top_val;
      done_next    = 1'b1;
    end else if (pop_deep) begin
      // Drop the count now; the result follows once the RAM answers
      count_next   = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      count          <= '0;
      capacity_limit <= CAP_RESET;
      done           <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
      if (cfg_wr_en) begin
        capacity_limit <= cfg_wr_data;
      end
    end
  end

  // Payload registers: top entry and result word
  always_ff @(posedge clk) begin
    top_val <= top_val_next;
    top_min <= top_min_next;
    if (done_next) begin
      popped_value <= popped_next;
      current_min  <= (count_next == '0) ? ALL_ONES : top_min_next;
      is_empty     <= (count_next == '0);
      is_full      <= (CMP_W'(count_next) >= eff_cap);
      status       <= status_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_read_gives_result : assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("RAM read cycle did not produce a result word");

  a_deep_pop_stalls : assert property (@(posedge clk) disable iff (rst)
    pop_deep |=> (busy && !done))
    else $error("deep pop did not wait for the RAM read");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= CMP_W'(DEPTH))
    else $error("entry count beyond stack depth");

  a_underflow_empty : assert property (@(posedge clk) disable iff (rst)
    (done && (status == STATUS_UNDERFLOW)) |-> (is_empty && (popped_value == ALL_ONES)))
    else $error("underflow result not reported as empty");

  a_push_count : assert property (@(posedge clk) disable iff (rst)
    push_ok |=> (count == $past(count) + CNT_W'(1)))
    else $error("accepted push did not advance the count");

endmodule

`default_nettype wire

// File: hw/rtl/mts_ram.sv
// ----------------------------------------------------------------------------
// mts_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
